// File: sv/kmp_pkg.sv
// Shared beat types and command codes for the KMP stream matcher.
`timescale 1ns / 1ps

package kmp_pkg;

  // Command codes carried in the input beat
  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_CLEAR   = 2'd3
  } kmp_cmd_e;

  // Input beat
  typedef struct packed {
    kmp_cmd_e   cmd;
    logic [7:0] symbol;
  } kmp_in_t;

  // Result beat
  typedef struct packed {
    logic        match;
    logic [31:0] match_start;
    logic        any_match;
    logic        pattern_full;
  } kmp_out_t;

endpackage

// File: sv/kmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/kmp_ctrl.sv
// Sequencer: failure-link walks over the pattern and failure memories.
`timescale 1ns / 1ps

module kmp_ctrl #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  kmp_pkg::kmp_in_t               in_data_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output kmp_pkg::kmp_out_t              res_o,
  output logic [$clog2(MAX_PATTERN)-1:0] p_raddr_o,
  output logic [$clog2(MAX_PATTERN)-1:0] f_raddr_o,
  input  logic [7:0]                     p_rdata_i,
  input  logic [$clog2(MAX_PATTERN)-1:0] f_rdata_i,
  output logic                           we_o,
  output logic [$clog2(MAX_PATTERN)-1:0] waddr_o,
  output logic [7:0]                     p_wdata_o,
  output logic [$clog2(MAX_PATTERN)-1:0] f_wdata_o
);

  import kmp_pkg::*;

  localparam int IDX_W   = $clog2(MAX_PATTERN);
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int START_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_TAIL = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [IDX_W-1:0]         bpre_q, bpre_d;
  logic [IDX_W-1:0]         mpre_q, mpre_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     found_q, found_d;
  logic                     text_q, text_d;
  logic [7:0]               sym_q, sym_d;

  logic                     eq;
  logic [LEN_W-1:0]         kn;
  logic [LEN_W-1:0]         len_m1;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [START_W-1:0]       start_wide;
  logic [IDX_W-1:0]         walk_src;
  logic                     tail_rd;
  logic                     pat_full;
  logic                     hit;

  // Step arithmetic
  assign eq         = (p_rdata_i == sym_q);
  assign kn         = LEN_W'(k_q) + LEN_W'(eq);
  assign len_m1     = len_q - LEN_W'(1);
  assign pos_inc    = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);
  assign start_wide = START_W'(pos_q) - START_W'(len_q) + START_W'(1);

  // Read addresses: start prefix on accept, failure link while walking
  always_comb begin
    if (state_q == ST_IDLE) begin
      walk_src = (in_data_i.cmd == CMD_TEXT) ? mpre_q : bpre_q;
    end else begin
      walk_src = f_rdata_i;
    end
  end

  assign p_raddr_o = walk_src;
  assign f_raddr_o = tail_rd ? len_m1[IDX_W-1:0] : walk_src - IDX_W'(1);

  // Writes always land at the current pattern length
  assign waddr_o   = len_q[IDX_W-1:0];
  assign p_wdata_o = (state_q == ST_IDLE) ? in_data_i.symbol : sym_q;
  assign f_wdata_o = (state_q == ST_IDLE) ? '0 : kn[IDX_W-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    bpre_d      = bpre_q;
    mpre_d      = mpre_q;
    k_d         = k_q;
    pos_d       = pos_q;
    found_d     = found_q;
    text_d      = text_q;
    sym_d       = sym_q;
    res_valid_o = 1'b0;
    we_o        = 1'b0;
    tail_rd     = 1'b0;
    pat_full    = 1'b0;
    hit         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          sym_d = in_data_i.symbol;
          k_d   = walk_src;
          unique case (in_data_i.cmd)
            CMD_APPEND: begin
              text_d = 1'b0;
              if (len_q == LEN_W'(MAX_PATTERN)) begin
                pat_full    = 1'b1;
                res_valid_o = 1'b1;
              end else if (len_q == '0) begin
                // first byte: border is empty, nothing to walk
                we_o        = 1'b1;
                bpre_d      = '0;
                len_d       = LEN_W'(1);
                res_valid_o = 1'b1;
              end else begin
                state_d = ST_WALK;
              end
            end
            CMD_TEXT: begin
              text_d = 1'b1;
              if (len_q == '0) begin
                pos_d       = pos_inc;
                res_valid_o = 1'b1;
              end else begin
                state_d = ST_WALK;
              end
            end
            CMD_RESTART: begin
              mpre_d      = '0;
              pos_d       = '0;
              found_d     = 1'b0;
              res_valid_o = 1'b1;
            end
            CMD_CLEAR: begin
              len_d       = '0;
              bpre_d      = '0;
              mpre_d      = '0;
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (k_q != '0 && !eq) begin
          // mismatch: follow the failure link, next read already issued
          k_d = f_rdata_i;
        end else if (!text_q) begin
          we_o        = 1'b1;
          bpre_d      = kn[IDX_W-1:0];
          len_d       = len_q + LEN_W'(1);
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end else if (kn == len_q) begin
          // full occurrence: fetch the border of the whole pattern
          tail_rd = 1'b1;
          state_d = ST_TAIL;
        end else begin
          mpre_d      = kn[IDX_W-1:0];
          pos_d       = pos_inc;
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_TAIL: begin
        hit         = 1'b1;
        mpre_d      = f_rdata_i;
        found_d     = 1'b1;
        pos_d       = pos_inc;
        res_valid_o = 1'b1;
        state_d     = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Result beat
  always_comb begin
    res_o              = '0;
    res_o.match        = hit;
    res_o.match_start  = hit ? start_wide[31:0] : 32'd0;
    res_o.any_match    = found_d;
    res_o.pattern_full = pat_full;
  end

  assign busy_o = (state_q != ST_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      bpre_q  <= '0;
      mpre_q  <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      bpre_q  <= bpre_d;
      mpre_q  <= mpre_d;
      pos_q   <= pos_d;
      found_q <= found_d;
    end
  end

  // Walk payload
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    text_q <= text_d;
    sym_q  <= sym_d;
  end

`ifndef SYNTH
  a_mpre_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) ? (mpre_q == '0) : (LEN_W'(mpre_q) < len_q))
    else $error("match prefix not below pattern length");

  a_bpre_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (LEN_W'(bpre_q) < len_q))
    else $error("build prefix not below pattern length");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !accept_i)
    else $error("beat accepted during a walk");

  a_tail_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL) |-> $past(state_q == ST_WALK))
    else $error("tail state not entered from a walk");
`endif

endmodule

// File: sv/kmp_stream_matcher.sv
// Top level of the KMP stream matcher: memories, sequencer and result register.
`timescale 1ns / 1ps

//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | kmp_in_t  {cmd, symbol}
//  out     | output    | out_valid_o / out_stall_i | kmp_out_t {match, ...}
//
//  Restart, clear, dropped appends, the first byte of a pattern and text with an
//  empty pattern complete in the idle state. Any other append or text byte walks
//  the failure links, and a text byte that completes a match also passes through
//  the tail state; each link followed costs one memory read.
//  Reset clears lengths, prefixes, position and flags; the memories are not
//  cleared since only written entries are ever read.
//  in_stall_o is high during a walk and while a finished result is held back.

module kmp_stream_matcher #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kmp_pkg::kmp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kmp_pkg::kmp_out_t out_data_o
);

  import kmp_pkg::*;

  localparam int IDX_W = $clog2(MAX_PATTERN);

  logic             accept;
  logic             busy;
  logic             res_valid;
  kmp_out_t         res;
  logic [IDX_W-1:0] p_raddr, f_raddr, waddr;
  logic [7:0]       p_rdata, p_wdata;
  logic [IDX_W-1:0] f_rdata, f_wdata;
  logic             we;
  logic             out_valid_q, out_valid_d;
  kmp_out_t         out_data_q;

  // Input handshake
  assign in_stall_o = busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  kmp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  kmp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PATTERN)
  ) u_failure_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  kmp_ctrl #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .p_raddr_o   (p_raddr),
    .f_raddr_o   (f_raddr),
    .p_rdata_i   (p_rdata),
    .f_rdata_i   (f_rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .p_wdata_o   (p_wdata),
    .f_wdata_o   (f_wdata)
  );

  // Output register
  assign out_valid_d = res_valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result overwrites a held beat");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("input open during a walk");

  a_match_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.match) |-> out_data_q.any_match)
    else $error("match without sticky flag");
`endif

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the KMP stream matcher: stimulus, predictor and result checker.
`timescale 1ns / 1ps

module tb_top;
  import kmp_pkg::*;

  localparam int          MAXP      = 64;
  localparam longint      POS_LIMIT = 64'hFFFF_FFFF;
  localparam int          CYCLE_CAP = 1000000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall_o;
  kmp_in_t  in_data = '0;
  logic     out_valid_o;
  logic     out_stall = 1'b0;
  kmp_out_t out_data_o;

  // Predictor state
  logic [7:0]      pat_mem [MAXP];
  logic [6:0]      fail_mem [MAXP];
  int unsigned     pat_len;
  int unsigned     build_k;
  int unsigned     match_k;
  longint unsigned text_pos;
  bit              found;

  kmp_out_t awaited_results [$];
  kmp_out_t want_r;

  // Handshake pacing and bookkeeping
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          err_count = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_match = 0;
  int unsigned n_full = 0;

  kmp_stream_matcher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Extend a prefix length by one byte, following failure links on a mismatch
  function automatic int unsigned prefix_extend(int unsigned k, logic [7:0] c);
    while (k > 0 && k < MAXP && pat_mem[k] != c)
      k = 32'(fail_mem[k-1]);
    if (k < MAXP && pat_mem[k] == c)
      k++;
    return k;
  endfunction

  // Expected result of one accepted beat
  task automatic match_step(kmp_in_t b);
    kmp_out_t    r;
    int unsigned k;
    r = '0;
    case (b.cmd)
      CMD_APPEND: begin
        if (pat_len >= MAXP) begin
          r.pattern_full = 1'b1;
        end else begin
          pat_mem[pat_len] = b.symbol;
          build_k = (pat_len == 0) ? 0 : prefix_extend(build_k, b.symbol);
          fail_mem[pat_len] = 7'(build_k);
          pat_len++;
        end
      end
      CMD_TEXT: begin
        if (pat_len > 0) begin
          k = prefix_extend(match_k, b.symbol);
          if (k >= pat_len) begin
            r.match       = 1'b1;
            r.match_start = 32'(text_pos - pat_len + 1);
            found         = 1'b1;
            k             = 32'(fail_mem[pat_len-1]);
          end
          match_k = k;
        end
        if (text_pos < POS_LIMIT)
          text_pos++;
      end
      CMD_RESTART: begin
        match_k  = 0;
        text_pos = 0;
        found    = 1'b0;
      end
      default: begin
        pat_len = 0;
        build_k = 0;
        match_k = 0;
      end
    endcase
    r.any_match = found;
    awaited_results = {awaited_results, r};
  endtask

  // Offer one beat after a random gap; entered and left at a falling edge
  task automatic send_beat(kmp_cmd_e c, logic [7:0] s);
    int      gap;
    kmp_in_t b;
    b.cmd    = c;
    b.symbol = s;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall_o);
    match_step(b);
    n_sent++;
    @(negedge clk);
  endtask

  // Sender pauses until every result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endtask

  // Output stall: long hold first, then the per-beat random stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (awaited_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat, expected none actual %h", $time, out_data_o);
      end else begin
        want_r = awaited_results.pop_front();
        report_field("match", 32'(want_r.match), 32'(out_data_o.match));
        report_field("match_start", want_r.match_start, out_data_o.match_start);
        report_field("any_match", 32'(want_r.any_match), 32'(out_data_o.any_match));
        report_field("pattern_full", 32'(want_r.pattern_full),
                     32'(out_data_o.pattern_full));
        n_checked++;
        if (out_data_o.match) n_match++;
        if (out_data_o.pattern_full) n_full++;
      end
      stall_left = idle_on ? $urandom_range(0, 15) : 0;
    end
  end

  // Extremes, every command, overlap, growth mid-text, restart and clear
  task automatic test_directed();
    send_beat(CMD_TEXT, 8'h00);      // empty pattern never matches
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_APPEND, 8'hFF);
    send_beat(CMD_APPEND, 8'hFF);
    repeat (3) send_beat(CMD_TEXT, 8'hFF);   // overlapping hits
    send_beat(CMD_APPEND, 8'h00);    // pattern grows while text is running
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_RESTART, 8'hA5);   // clears sticky flag and position
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_CLEAR, 8'h5A);     // position and sticky flag survive
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_APPEND, 8'h80);
    send_beat(CMD_APPEND, 8'h7F);
    send_beat(CMD_TEXT, 8'h80);
    send_beat(CMD_TEXT, 8'h7F);
    send_beat(CMD_TEXT, 8'h80);
    wait_drain();
  endtask

  // Fill the pattern to capacity, drop extra bytes, then match a periodic text
  task automatic test_pattern_full();
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    sym_a = 8'($urandom_range(0, 255));
    sym_b = sym_a ^ 8'($urandom_range(1, 255));
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_RESTART, 8'h00);
    repeat (MAXP / 2) begin
      send_beat(CMD_APPEND, sym_a);
      send_beat(CMD_APPEND, sym_b);
    end
    repeat (3) send_beat(CMD_APPEND, 8'($urandom_range(0, 255)));
    repeat (40) begin
      send_beat(CMD_TEXT, sym_a);
      send_beat(CMD_TEXT, sym_b);
    end
    send_beat(CMD_TEXT, sym_a);
    send_beat(CMD_TEXT, sym_a);      // mismatch deep in the pattern: long walk
    repeat (36) begin
      send_beat(CMD_TEXT, sym_a);
      send_beat(CMD_TEXT, sym_b);
    end
    send_beat(CMD_CLEAR, 8'h00);
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering beats
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_left <= 300;
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_APPEND, 8'h3C);
    send_beat(CMD_APPEND, 8'hC3);
    repeat (20) begin
      send_beat(CMD_TEXT, 8'h3C);
      send_beat(CMD_TEXT, 8'hC3);
    end
    wait_drain();
    idle_on = 1'b1;
  endtask

  // Episodes of pattern setup and text over a small random alphabet, with noise
  task automatic test_random_streams(int unsigned n_items);
    logic [7:0]  alpha [3];
    int unsigned last_sym;
    int unsigned plen;
    int unsigned tlen;
    int unsigned roll;
    int unsigned stop_at;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      idle_on  = ($urandom_range(0, 7) != 0);
      last_sym = $urandom_range(1, 2);
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) != 0) send_beat(CMD_RESTART, 8'($urandom_range(0, 255)));
      plen = ($urandom_range(0, 29) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 6);
      repeat (plen) send_beat(CMD_APPEND, alpha[$urandom_range(0, last_sym)]);
      tlen = $urandom_range(5, 40);
      repeat (tlen) begin
        roll = $urandom_range(0, 99);
        if (roll < 85)
          send_beat(CMD_TEXT, alpha[$urandom_range(0, last_sym)]);
        else if (roll < 90)
          send_beat(CMD_TEXT, 8'($urandom_range(0, 255)));
        else if (roll < 93)
          send_beat(CMD_APPEND, alpha[$urandom_range(0, last_sym)]);
        else if (roll < 96)
          send_beat(CMD_RESTART, 8'($urandom_range(0, 255)));
        else
          send_beat(kmp_cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) wait_drain();
    end
    idle_on = 1'b1;
    wait_drain();
  endtask

  // Test sequence
  initial begin
    foreach (pat_mem[i]) begin
      pat_mem[i]  = '0;
      fail_mem[i] = '0;
    end
    pat_len  = 0;
    build_k  = 0;
    match_k  = 0;
    text_pos = 0;
    found    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_pattern_full();
    test_backpressure();
    test_random_streams(900);

    wait_drain();
    repeat (200) @(negedge clk);
    $display("Sent %0d beats, checked %0d results: %0d matches, %0d dropped pattern bytes.",
             n_sent, n_checked, n_match, n_full);
    $display("Covered overlap, growth mid-text, capacity, restart, clear and back-pressure.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
